/* hw/rtl/encoder_button_event_translator_defines.svh */
// Assertion macros for the checker file of the event translator.
`ifndef ENCODER_BUTTON_EVENT_TRANSLATOR_DEFINES_SVH
`define ENCODER_BUTTON_EVENT_TRANSLATOR_DEFINES_SVH

// Check a property outside reset.
`define EBET_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("event translator check failed");

// Check a property at every edge, reset included.
`define EBET_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("event translator reset check failed");

`endif

/* hw/rtl/ebet_pkg.sv */
// Types, codes and helpers of the encoder and button event translator.
package ebet_pkg;

  // Width of the kept positions; they saturate to this many signed bits
  localparam int POSITION_BITS = 32;
  localparam longint PosHiL = (longint'(1) << (POSITION_BITS - 1)) - longint'(1);
  localparam logic signed [33:0] POS_HI = 34'(PosHiL);
  localparam logic signed [33:0] POS_LO = -POS_HI - 34'sd1;
  localparam logic signed [33:0] S32_HI = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] S32_LO = -S32_HI - 34'sd1;

  // Event codes
  typedef enum logic [3:0] {
    CMD_ENABLED          = 4'd0,
    CMD_DISABLED         = 4'd1,
    CMD_IDLE             = 4'd2,
    CMD_CHANGED          = 4'd3,
    CMD_CHANGED_PRESSED  = 4'd4,
    CMD_CHANGED_RELEASED = 4'd5,
    CMD_RELEASED         = 4'd7,
    CMD_CLICKED          = 4'd8,
    CMD_LONG_CLICKED     = 4'd11,
    CMD_LONG_PRESS       = 4'd12
  } cmd_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_MIN_POS      = 3'd0;
  localparam logic [2:0] CFG_MAX_POS      = 3'd1;
  localparam logic [2:0] CFG_WRAP_POS     = 3'd2;
  localparam logic [2:0] CFG_MIN_HELD_POS = 3'd3;
  localparam logic [2:0] CFG_MAX_HELD_POS = 3'd4;
  localparam logic [2:0] CFG_WRAP_HELD    = 3'd5;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [15:0] step_amount;
    logic               button_down;
    logic               encoder_quiet;
    logic               button_quiet;
    logic               may_emit;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         event_code;
    logic signed [31:0] position;
    logic signed [31:0] pressed_position;
    logic signed [31:0] applied_step;
  } out_word_t;

  // Limits of one position
  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               wrap;
  } lim_t;

  // Saturate to the position width
  function automatic logic signed [31:0] pos_sat(input logic signed [33:0] v);
    logic signed [33:0] r;
    if (v > POS_HI) begin
      r = POS_HI;
    end else if (v < POS_LO) begin
      r = POS_LO;
    end else begin
      r = v;
    end
    return r[31:0];
  endfunction

  // Saturate to 32 signed bits
  function automatic logic signed [31:0] s32_sat(input logic signed [33:0] v);
    logic signed [33:0] r;
    if (v > S32_HI) begin
      r = S32_HI;
    end else if (v < S32_LO) begin
      r = S32_LO;
    end else begin
      r = v;
    end
    return r[31:0];
  endfunction

endpackage

/* hw/rtl/encoder_button_event_translator.sv */
// Encoder and push-button event translator, top level.
// Usage:
//   Input channel in_valid/in_ready/in_word carries one encoder or button
//   event per word. Result channel out_valid/out_ready/out_word carries the
//   translated event with both positions and the applied step; an event
//   gives zero or one result word.
//   cfg_we/cfg_index/cfg_wdata write the six limit registers; write them
//   only while no event is in flight.
// Timing:
//   A word accepted at an edge sits in the input register, and its result
//   is loaded into the output register when that register is free. One word
//   per cycle is sustained while the receiver takes every result; the
//   position add, limit compares and step subtract are combinational logic
//   that also carries the position state from one word to the next.
// Reset (synchronous, rst_n low) clears positions, mode, count, limits and
// both valid flags.
// When the receiver stalls, the result word holds; the input register
// still takes one more word, then in_ready drops until out_ready returns.
module encoder_button_event_translator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ebet_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ebet_pkg::out_word_t  out_word,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_wdata
);

  ebet_pkg::lim_t      lim_norm_r, lim_held_r;
  ebet_pkg::in_word_t  s1_word_r;
  logic                s1_valid_r;
  ebet_pkg::out_word_t out_word_r;
  logic                out_valid_r;

  logic signed [31:0]  norm_pos_r, norm_pos_nxt;
  logic signed [31:0]  held_pos_r, held_pos_nxt;
  logic signed [31:0]  last_step_r, last_step_nxt;
  logic                turning_r, turning_nxt;
  logic [15:0]         turn_cnt_r, turn_cnt_nxt;

  ebet_pkg::lim_t      mv_lim;
  logic signed [31:0]  mv_old, mv_new, mv_applied;
  logic [3:0]          code;
  logic                drop;
  logic                emit;
  logic                out_free;
  logic                s1_fire;

  // Handshake
  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_norm_r <= '0;
      lim_held_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ebet_pkg::CFG_MIN_POS:      lim_norm_r.lo   <= cfg_wdata;
        ebet_pkg::CFG_MAX_POS:      lim_norm_r.hi   <= cfg_wdata;
        ebet_pkg::CFG_WRAP_POS:     lim_norm_r.wrap <= cfg_wdata[0];
        ebet_pkg::CFG_MIN_HELD_POS: lim_held_r.lo   <= cfg_wdata;
        ebet_pkg::CFG_MAX_HELD_POS: lim_held_r.hi   <= cfg_wdata;
        ebet_pkg::CFG_WRAP_HELD:    lim_held_r.wrap <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= in_word;
    end
  end

  // Select the position that matches the button state
  assign mv_old = s1_word_r.button_down ? held_pos_r : norm_pos_r;
  assign mv_lim = s1_word_r.button_down ? lim_held_r : lim_norm_r;

  ebet_move u_move (
    .old_pos (mv_old),
    .step    (s1_word_r.step_amount),
    .lim     (mv_lim),
    .new_pos (mv_new),
    .applied (mv_applied)
  );

  // Translate the event and work out the next state
  always_comb begin
    code          = s1_word_r.command;
    drop          = 1'b0;
    norm_pos_nxt  = norm_pos_r;
    held_pos_nxt  = held_pos_r;
    last_step_nxt = last_step_r;
    turning_nxt   = turning_r;
    turn_cnt_nxt  = turn_cnt_r;

    if (code == ebet_pkg::CMD_ENABLED || code == ebet_pkg::CMD_DISABLED) begin
      drop = 1'b1;
    end else if (code == ebet_pkg::CMD_IDLE &&
                 !(s1_word_r.encoder_quiet && s1_word_r.button_quiet)) begin
      drop = 1'b1;
    end else begin
      if (code == ebet_pkg::CMD_CHANGED) begin
        last_step_nxt = mv_applied;
        if (s1_word_r.button_down) begin
          turning_nxt  = 1'b1;
          held_pos_nxt = mv_new;
        end else begin
          norm_pos_nxt = mv_new;
        end
        if (mv_applied == 32'sd0) begin
          drop = 1'b1;
        end else if (turning_nxt) begin
          code = ebet_pkg::CMD_CHANGED_PRESSED;
          if (turn_cnt_r != 16'hFFFF) begin
            turn_cnt_nxt = turn_cnt_r + 16'd1;
          end
        end
      end
      // Pressed-turn mode renames or swallows button events
      if (!drop && turning_nxt) begin
        if (code == ebet_pkg::CMD_LONG_PRESS) begin
          drop = 1'b1;
        end else if (code == ebet_pkg::CMD_RELEASED && turn_cnt_nxt != 16'd0) begin
          code = ebet_pkg::CMD_CHANGED_RELEASED;
        end else if (code == ebet_pkg::CMD_CLICKED ||
                     code == ebet_pkg::CMD_LONG_CLICKED) begin
          drop         = 1'b1;
          turning_nxt  = 1'b0;
          turn_cnt_nxt = 16'd0;
        end
      end
    end
    emit = !drop && s1_word_r.may_emit;
  end

  // Advance the kept state when the input register hands on its word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_pos_r  <= '0;
      held_pos_r  <= '0;
      last_step_r <= '0;
      turning_r   <= 1'b0;
      turn_cnt_r  <= '0;
    end else if (s1_fire) begin
      norm_pos_r  <= norm_pos_nxt;
      held_pos_r  <= held_pos_nxt;
      last_step_r <= last_step_nxt;
      turning_r   <= turning_nxt;
      turn_cnt_r  <= turn_cnt_nxt;
    end
  end

  // Result register: load on a new result, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_word_r.event_code       <= code;
      out_word_r.position         <= norm_pos_nxt;
      out_word_r.pressed_position <= held_pos_nxt;
      out_word_r.applied_step     <= last_step_nxt;
    end
  end

endmodule

/* hw/rtl/ebet_move.sv */
// One position move: saturating add, limit by clamp or wrap, applied step.
module ebet_move (
  input  logic signed [31:0] old_pos,
  input  logic signed [15:0] step,
  input  ebet_pkg::lim_t     lim,
  output logic signed [31:0] new_pos,
  output logic signed [31:0] applied
);

  logic signed [33:0] sum;
  logic signed [31:0] moved;
  logic signed [31:0] limited;
  logic               lim_on;

  // Add the step and saturate
  assign sum   = 34'(old_pos) + 34'(step);
  assign moved = ebet_pkg::pos_sat(sum);
  assign lim_on = !(lim.lo == 32'sd0 && lim.hi == 32'sd0);

  // Apply the limits, maximum first
  always_comb begin
    limited = moved;
    if (lim_on) begin
      if (moved > lim.hi) begin
        limited = lim.wrap ? lim.lo : lim.hi;
      end else if (moved < lim.lo) begin
        limited = lim.wrap ? lim.hi : lim.lo;
      end
    end
  end

  assign new_pos = ebet_pkg::pos_sat(34'(limited));
  assign applied = ebet_pkg::s32_sat(34'(new_pos) - 34'(old_pos));

endmodule

/* hw/rtl/ebet_checker.sv */
// Port checks for the event translator, bound to the top level.
`include "encoder_button_event_translator_defines.svh"

module ebet_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ebet_pkg::out_word_t out_word
);

  logic ctl_out;
  logic turn_out;

  // Flag enable and disable codes and plain turns on the result port
  assign ctl_out  = out_word.event_code == ebet_pkg::CMD_ENABLED ||
                    out_word.event_code == ebet_pkg::CMD_DISABLED;
  assign turn_out = out_valid && out_word.event_code == ebet_pkg::CMD_CHANGED;

  // A stalled result word holds
  `EBET_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word))
  // Input only backs up behind a stalled result
  `EBET_ASSERT(a_in_stall, in_valid && !in_ready |-> out_valid && !out_ready)
  // Enable and disable events never come out
  `EBET_ASSERT(a_no_enable, out_valid |-> !ctl_out)
  // A plain turn always moved its position; pressed codes may pass straight through
  `EBET_ASSERT(a_turn_moves, turn_out |-> out_word.applied_step != 32'sd0)
  // Reset empties the result register
  `EBET_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind encoder_button_event_translator ebet_checker u_ebet_checker (.*);

/* sim/tb.sv */
// Self-checking testbench for the encoder and button event translator.
module tb;

  // Event codes that the package leaves unnamed and that pass unchanged
  localparam logic [3:0] CODE_SPARE = 4'd6;
  localparam logic [3:0] CODE_TOP   = 4'd15;

  localparam logic signed [31:0] LIMIT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] LIMIT_MAX = 32'sh7FFF_FFFF;

  localparam int PHASE_WORDS    = 185;
  localparam int PHASES         = 9;
  localparam int DRAIN_CYCLES   = 6;
  localparam int LONG_HOLD      = 100;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct {
    ebet_pkg::in_word_t  w;
    bit                  typed;
    bit                  emits;
    ebet_pkg::out_word_t res;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ebet_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ebet_pkg::out_word_t out_word;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_index = ebet_pkg::CFG_MIN_POS;
  logic [31:0]         cfg_wdata = '0;

  // Predictor state and its copy of the limit registers
  longint          pos_normal;
  longint          pos_held;
  longint          step_last;
  bit              held_mode;
  int unsigned     held_turns;
  ebet_pkg::lim_t  lim_normal;
  ebet_pkg::lim_t  lim_held;

  ebet_pkg::out_word_t results_due[$];
  stim_row_t   directed_rows[$];
  int          words_in = 0;
  int          mismatches = 0;
  int          stall_cycles = 0;
  bit          sender_steady = 1'b0;
  bit          long_hold_done = 1'b0;

  encoder_button_event_translator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Clip a value to a signed range of the given width
  function automatic longint sat_signed(longint v, int bits);
    longint top;
    longint bottom;
    top = (longint'(1) << (bits - 1)) - 1;
    bottom = -top - 1;
    if (v > top) return top;
    if (v < bottom) return bottom;
    return v;
  endfunction

  // Move one position by the step within its limits; return the step applied
  function automatic longint advance_position(ref longint pos, input longint delta,
                                              input ebet_pkg::lim_t lim);
    longint prior;
    longint nxt;
    longint lo;
    longint hi;
    prior = pos;
    lo = longint'($signed(lim.lo));
    hi = longint'($signed(lim.hi));
    nxt = sat_signed(prior + delta, ebet_pkg::POSITION_BITS);
    if (!(lo == 0 && hi == 0)) begin
      if (nxt > hi) begin
        nxt = lim.wrap ? lo : hi;
      end else if (nxt < lo) begin
        nxt = lim.wrap ? hi : lo;
      end
    end
    nxt = sat_signed(nxt, ebet_pkg::POSITION_BITS);
    pos = nxt;
    return sat_signed(nxt - prior, 32);
  endfunction

  // Translate one event; return 1 when a result word is due
  function automatic bit translate_event(input ebet_pkg::in_word_t w,
                                         output ebet_pkg::out_word_t r);
    logic [3:0] code;
    code = w.command;
    r = '0;
    if (code == ebet_pkg::CMD_ENABLED || code == ebet_pkg::CMD_DISABLED) return 1'b0;
    if (code == ebet_pkg::CMD_IDLE && !(w.encoder_quiet && w.button_quiet)) return 1'b0;
    if (code == ebet_pkg::CMD_CHANGED) begin
      if (w.button_down) begin
        held_mode = 1'b1;
        step_last = advance_position(pos_held, longint'($signed(w.step_amount)),
                                     lim_held);
      end else begin
        step_last = advance_position(pos_normal, longint'($signed(w.step_amount)),
                                     lim_normal);
      end
      if (step_last == 0) return 1'b0;
      if (held_mode) begin
        code = ebet_pkg::CMD_CHANGED_PRESSED;
        if (held_turns < 65535) held_turns++;
      end
    end
    // Turning with the button held renames or swallows button events
    if (held_mode) begin
      if (code == ebet_pkg::CMD_LONG_PRESS) return 1'b0;
      if (code == ebet_pkg::CMD_RELEASED && held_turns != 0)
        code = ebet_pkg::CMD_CHANGED_RELEASED;
      if (code == ebet_pkg::CMD_CLICKED || code == ebet_pkg::CMD_LONG_CLICKED) begin
        held_mode = 1'b0;
        held_turns = 0;
        return 1'b0;
      end
    end
    if (!w.may_emit) return 1'b0;
    r.event_code       = code;
    r.position         = pos_normal[31:0];
    r.pressed_position = pos_held[31:0];
    r.applied_step     = step_last[31:0];
    return 1'b1;
  endfunction

  function automatic ebet_pkg::in_word_t ev(logic [3:0] c, logic signed [15:0] s, bit d,
                                            bit eq, bit bq, bit me);
    ebet_pkg::in_word_t w;
    w.command       = c;
    w.step_amount   = s;
    w.button_down   = d;
    w.encoder_quiet = eq;
    w.button_quiet  = bq;
    w.may_emit      = me;
    return w;
  endfunction

  function automatic ebet_pkg::out_word_t res(logic [3:0] c, logic signed [31:0] p,
                                              logic signed [31:0] h,
                                              logic signed [31:0] s);
    ebet_pkg::out_word_t r;
    r.event_code       = c;
    r.position         = p;
    r.pressed_position = h;
    r.applied_step     = s;
    return r;
  endfunction

  function automatic void add_checked(ebet_pkg::in_word_t w);
    stim_row_t row;
    row.w = w;
    row.typed = 1'b0;
    row.emits = 1'b0;
    row.res = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_typed(ebet_pkg::in_word_t w, bit emits,
                                    ebet_pkg::out_word_t r);
    stim_row_t row;
    row.w = w;
    row.typed = 1'b1;
    row.emits = emits;
    row.res = r;
    directed_rows.push_back(row);
  endfunction

  // Mostly no gap, some short ones and a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic signed [15:0] random_step();
    int r;
    int v;
    r = $urandom_range(9);
    if (r < 6) begin
      v = $urandom_range(40);
      v = v - 20;
    end else if (r < 8) begin
      v = $urandom;
    end else if (r == 8) begin
      v = $urandom_range(1) ? 32767 : -32768;
    end else begin
      v = $urandom_range(32767);
    end
    return v[15:0];
  endfunction

  function automatic ebet_pkg::in_word_t make_word(logic [3:0] c, bit d);
    return ev(c, random_step(), d, $urandom_range(3) != 0, $urandom_range(3) != 0,
              $urandom_range(7) != 0);
  endfunction

  function automatic ebet_pkg::in_word_t random_event();
    int r;
    logic [3:0] c;
    r = $urandom_range(99);
    if (r < 45) c = ebet_pkg::CMD_CHANGED;
    else if (r < 55) c = ebet_pkg::CMD_RELEASED;
    else if (r < 62) c = ebet_pkg::CMD_CLICKED;
    else if (r < 67) c = ebet_pkg::CMD_LONG_CLICKED;
    else if (r < 72) c = ebet_pkg::CMD_LONG_PRESS;
    else if (r < 80) c = ebet_pkg::CMD_IDLE;
    else if (r < 84) c = $urandom_range(1) ? ebet_pkg::CMD_ENABLED : ebet_pkg::CMD_DISABLED;
    else c = 4'($urandom_range(15));
    return make_word(c, 1'($urandom_range(1)));
  endfunction

  // Offer one word, wait for it to be taken, then note what it should give
  task automatic send_word(ebet_pkg::in_word_t w, bit typed, bit emits,
                           ebet_pkg::out_word_t r);
    int gap;
    bit fires;
    ebet_pkg::out_word_t predicted;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    fires = translate_event(w, predicted);
    words_in++;
    if (typed) begin
      if (emits) results_due.push_back(r);
    end else if (fires) begin
      results_due.push_back(predicted);
    end
  endtask

  // A plain turn run, a held turn run followed by a release and a click or long click, or a lone random word
  task automatic send_gesture();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 40) begin
      n = $urandom_range(6, 1);
      repeat (n) send_word(make_word(ebet_pkg::CMD_CHANGED, 1'b0), 1'b0, 1'b0, '0);
    end else if (r < 75) begin
      n = $urandom_range(5, 1);
      repeat (n) send_word(make_word(ebet_pkg::CMD_CHANGED, 1'b1), 1'b0, 1'b0, '0);
      if ($urandom_range(2) == 0)
        send_word(make_word(ebet_pkg::CMD_LONG_PRESS, 1'b1), 1'b0, 1'b0, '0);
      send_word(make_word(ebet_pkg::CMD_RELEASED, 1'b0), 1'b0, 1'b0, '0);
      send_word(make_word($urandom_range(1) ? ebet_pkg::CMD_CLICKED :
                          ebet_pkg::CMD_LONG_CLICKED, 1'b0),
                1'b0, 1'b0, '0);
      if ($urandom_range(3) == 0)
        send_word(make_word(ebet_pkg::CMD_IDLE, 1'b0), 1'b0, 1'b0, '0);
    end else begin
      send_word(random_event(), 1'b0, 1'b0, '0);
    end
  endtask

  // Drop valid, let every result arrive, then allow for words still in flight
  task automatic drain();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all six limit registers back to back
  task automatic set_limits(ebet_pkg::lim_t normal, ebet_pkg::lim_t held);
    cfg_we <= 1'b1;
    cfg_index <= ebet_pkg::CFG_MIN_POS;
    cfg_wdata <= normal.lo;
    @(posedge clk);
    cfg_index <= ebet_pkg::CFG_MAX_POS;
    cfg_wdata <= normal.hi;
    @(posedge clk);
    cfg_index <= ebet_pkg::CFG_WRAP_POS;
    cfg_wdata <= {31'd0, normal.wrap};
    @(posedge clk);
    cfg_index <= ebet_pkg::CFG_MIN_HELD_POS;
    cfg_wdata <= held.lo;
    @(posedge clk);
    cfg_index <= ebet_pkg::CFG_MAX_HELD_POS;
    cfg_wdata <= held.hi;
    @(posedge clk);
    cfg_index <= ebet_pkg::CFG_WRAP_HELD;
    cfg_wdata <= {31'd0, held.wrap};
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_normal = normal;
    lim_held = held;
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    ebet_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result word: code %0d pos %0d held %0d step %0d",
                   out_word.event_code, out_word.position, out_word.pressed_position,
                   out_word.applied_step);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (out_word.event_code !== want.event_code || out_word.position !== want.position ||
            out_word.pressed_position !== want.pressed_position ||
            out_word.applied_step !== want.applied_step) begin
          if (mismatches < 10)
            $display("mismatch: want code %0d pos %0d held %0d step %0d,",
                     want.event_code, want.position, want.pressed_position,
                     want.applied_step,
                     " got code %0d pos %0d held %0d step %0d",
                     out_word.event_code, out_word.position, out_word.pressed_position,
                     out_word.applied_step);
          mismatches++;
        end
      end
    end
  end

  // End the run when nothing has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: random stalls, steady stretches and one long hold-off
  initial begin
    int gap;
    bit rcv_steady;
    rcv_steady = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!long_hold_done && words_in >= 200) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (rcv_steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
      if ($urandom_range(199) == 0) rcv_steady = !rcv_steady;
    end
  end

  // Sender and run control
  initial begin
    ebet_pkg::lim_t normal_set[PHASES];
    ebet_pkg::lim_t held_set[PHASES];
    int target;
    int v;
    pos_normal = 0;
    pos_held = 0;
    step_last = 0;
    held_mode = 1'b0;
    held_turns = 0;
    lim_normal = '0;
    lim_held = '0;

    // Directed words, run with all limits at zero from reset
    add_typed(ev(ebet_pkg::CMD_ENABLED, 16'sd0, 1'b0, 1'b1, 1'b1, 1'b1), 1'b0, '0);
    add_typed(ev(ebet_pkg::CMD_DISABLED, 16'sd0, 1'b0, 1'b1, 1'b1, 1'b1), 1'b0, '0);
    add_typed(ev(ebet_pkg::CMD_IDLE, 16'sd0, 1'b0, 1'b1, 1'b1, 1'b1), 1'b1,
              res(ebet_pkg::CMD_IDLE, 32'sd0, 32'sd0, 32'sd0));
    add_typed(ev(ebet_pkg::CMD_IDLE, 16'sd0, 1'b0, 1'b0, 1'b1, 1'b1), 1'b0, '0);
    add_typed(ev(ebet_pkg::CMD_IDLE, 16'sd0, 1'b0, 1'b1, 1'b0, 1'b1), 1'b0, '0);
    add_typed(ev(ebet_pkg::CMD_CHANGED, 16'sd5, 1'b0, 1'b1, 1'b1, 1'b1), 1'b1,
              res(ebet_pkg::CMD_CHANGED, 32'sd5, 32'sd0, 32'sd5));
    add_typed(ev(ebet_pkg::CMD_CHANGED, 16'sd0, 1'b0, 1'b1, 1'b1, 1'b1), 1'b0, '0);
    add_typed(ev(ebet_pkg::CMD_CHANGED, -16'sd32768, 1'b0, 1'b1, 1'b1, 1'b1), 1'b1,
              res(ebet_pkg::CMD_CHANGED, -32'sd32763, 32'sd0, -32'sd32768));
    add_typed(ev(ebet_pkg::CMD_CHANGED, 16'sd32767, 1'b1, 1'b1, 1'b1, 1'b1), 1'b1,
              res(ebet_pkg::CMD_CHANGED_PRESSED, -32'sd32763, 32'sd32767, 32'sd32767));
    add_typed(ev(ebet_pkg::CMD_LONG_PRESS, 16'sd0, 1'b1, 1'b1, 1'b1, 1'b1), 1'b0, '0);
    add_typed(ev(ebet_pkg::CMD_RELEASED, 16'sd0, 1'b0, 1'b1, 1'b1, 1'b1), 1'b1,
              res(ebet_pkg::CMD_CHANGED_RELEASED, -32'sd32763, 32'sd32767, 32'sd32767));
    add_checked(ev(CODE_SPARE, 16'sd1, 1'b0, 1'b1, 1'b1, 1'b1));
    add_typed(ev(ebet_pkg::CMD_CLICKED, 16'sd0, 1'b0, 1'b1, 1'b1, 1'b1), 1'b0, '0);
    add_checked(ev(ebet_pkg::CMD_RELEASED, 16'sd0, 1'b0, 1'b1, 1'b1, 1'b1));
    add_checked(ev(ebet_pkg::CMD_LONG_PRESS, 16'sd0, 1'b1, 1'b1, 1'b1, 1'b1));
    add_checked(ev(ebet_pkg::CMD_CLICKED, 16'sd0, 1'b0, 1'b1, 1'b1, 1'b1));
    // Held turn of zero enters the mode without a count
    add_typed(ev(ebet_pkg::CMD_CHANGED, 16'sd0, 1'b1, 1'b1, 1'b1, 1'b1), 1'b0, '0);
    add_checked(ev(ebet_pkg::CMD_RELEASED, 16'sd0, 1'b0, 1'b1, 1'b1, 1'b1));
    add_typed(ev(ebet_pkg::CMD_LONG_CLICKED, 16'sd0, 1'b0, 1'b1, 1'b1, 1'b1), 1'b0, '0);
    add_checked(ev(ebet_pkg::CMD_LONG_CLICKED, 16'sd0, 1'b0, 1'b1, 1'b1, 1'b1));
    // Gated word still moves the position
    add_typed(ev(ebet_pkg::CMD_CHANGED, 16'sd100, 1'b0, 1'b1, 1'b1, 1'b0), 1'b0, '0);
    add_checked(ev(ebet_pkg::CMD_IDLE, 16'sd0, 1'b0, 1'b1, 1'b1, 1'b1));
    add_checked(ev(CODE_TOP, -16'sd1, 1'b1, 1'b0, 1'b0, 1'b1));
    add_checked(ev(ebet_pkg::CMD_CHANGED, -16'sd1, 1'b1, 1'b0, 1'b0, 1'b1));
    add_checked(ev(ebet_pkg::CMD_CHANGED_PRESSED, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b1));

    // Limit settings per phase; the order walks positions up to saturation
    normal_set[0] = '{32'sd0, 32'sd0, 1'b0};
    held_set[0]   = '{32'sd0, 32'sd0, 1'b0};
    normal_set[1] = '{LIMIT_MIN, LIMIT_MAX, 1'b0};
    held_set[1]   = '{-32'sd100, 32'sd100, 1'b1};
    normal_set[2] = '{-32'sd50, 32'sd50, 1'b1};
    held_set[2]   = '{32'sd0, 32'sd0, 1'b1};
    normal_set[3] = '{32'sd2147483600, LIMIT_MAX, 1'b1};
    held_set[3]   = '{LIMIT_MIN, -32'sd2147483600, 1'b0};
    normal_set[4] = '{32'sd0, 32'sd0, 1'b0};
    held_set[4]   = '{LIMIT_MIN, LIMIT_MAX - 32'sd1, 1'b1};
    normal_set[5] = '{LIMIT_MIN, LIMIT_MAX - 32'sd1, 1'b1};
    held_set[5]   = '{32'sd0, 32'sd0, 1'b0};
    normal_set[6] = '{32'sd10, -32'sd10, 1'b0};
    held_set[6]   = '{32'sd5, 32'sd5, 1'b1};
    v = $urandom_range(300);
    normal_set[7].lo = -v;
    normal_set[7].hi = $urandom_range(300);
    normal_set[7].wrap = 1'($urandom_range(1));
    v = $urandom_range(300);
    held_set[7].lo = -v;
    held_set[7].hi = $urandom_range(300);
    held_set[7].wrap = 1'($urandom_range(1));
    normal_set[8] = '{$urandom, $urandom, 1'($urandom_range(1))};
    held_set[8]   = '{$urandom, $urandom, 1'($urandom_range(1))};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    foreach (directed_rows[i])
      send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].emits,
                directed_rows[i].res);
    drain();

    // Random part, one limit setting per phase
    for (int p = 0; p < PHASES; p++) begin
      set_limits(normal_set[p], held_set[p]);
      sender_steady = ($urandom_range(3) == 0);
      target = words_in + PHASE_WORDS;
      while (words_in < target) send_gesture();
      drain();
    end

    mismatches += results_due.size();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
